// ----- src/fl2n_pkg.sv -----
// shared constants and types for the float l2 norm accumulator
`default_nettype none
package fl2n_pkg;
	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [31:0] POS_INF = 32'h7F80_0000;
	localparam logic [31:0] POS_ZERO = 32'h0000_0000;

	typedef struct packed {
		logic        done;
		logic [31:0] bits;
	} sqrt_stat_t;

	function automatic logic is_nan(input logic [31:0] u);
		return (u[30:23] == 8'hFF) && (u[22:0] != 23'd0);
	endfunction
endpackage
`default_nettype wire

// ----- src/fl2n_sqrt.sv -----
// bit-serial correctly rounded single-precision square root
`default_nettype none
module fl2n_sqrt (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [31:0]         in_bits,
	output fl2n_pkg::sqrt_stat_t     stat
);
	typedef enum logic [1:0] {S_IDLE, S_NORM, S_ITER, S_DONE} state_t;

	state_t              state_q;
	logic                done_q;
	logic [31:0]         bits_q;
	logic [23:0]         m_q;
	logic signed [9:0]   p_q;
	logic [50:0]         num_q;
	logic [50:0]         res_q;
	logic [50:0]         bit_q;

	logic [50:0]         trial;
	logic [25:0]         madj;
	logic signed [9:0]   padj;
	logic signed [9:0]   bexp;
	logic [24:0]         q;
	logic [24:0]         qr;
	logic                inc;

	always_comb begin
		trial = res_q + bit_q;
		if (p_q[0]) begin
			madj = {1'b0, m_q, 1'b0};
			padj = p_q - 10'sd1;
		end else begin
			madj = {m_q, 2'b00};
			padj = p_q - 10'sd2;
		end
		bexp = (p_q >>> 1) + 10'sd139;
		q = res_q[25:1];
		inc = res_q[0] & ((num_q != 51'd0) | q[0]);
		qr = q + 25'(inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (fl2n_pkg::is_nan(in_bits)) begin
							bits_q <= fl2n_pkg::CANON_NAN;
							done_q <= 1'b1;
						end else if (in_bits[30:0] == 31'd0) begin
							bits_q <= in_bits;
							done_q <= 1'b1;
						end else if (in_bits[31]) begin
							bits_q <= fl2n_pkg::CANON_NAN;
							done_q <= 1'b1;
						end else if (in_bits[30:23] == 8'hFF) begin
							bits_q <= in_bits;
							done_q <= 1'b1;
						end else if (in_bits[30:23] == 8'd0) begin
							m_q <= {1'b0, in_bits[22:0]};
							p_q <= -10'sd149;
							done_q <= 1'b0;
							state_q <= S_NORM;
						end else begin
							m_q <= {1'b1, in_bits[22:0]};
							p_q <= $signed({2'b00, in_bits[30:23]}) - 10'sd150;
							done_q <= 1'b0;
							state_q <= S_NORM;
						end
					end else begin
						done_q <= 1'b0;
					end
				end
				S_NORM: begin
					if (m_q[23]) begin
						num_q <= {1'b0, madj, 24'd0};
						p_q <= padj;
						res_q <= '0;
						bit_q <= 51'd1 << 50;
						state_q <= S_ITER;
					end else begin
						m_q <= {m_q[22:0], 1'b0};
						p_q <= p_q - 10'sd1;
					end
				end
				S_ITER: begin
					if (num_q >= trial) begin
						num_q <= num_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (qr[24]) begin
						bits_q <= {1'b0, 8'(bexp + 10'sd1), 23'd0};
					end else begin
						bits_q <= {1'b0, bexp[7:0], qr[22:0]};
					end
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					done_q <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.done = done_q;
	assign stat.bits = bits_q;
endmodule
`default_nettype wire

// ----- src/float_l2_norm_accumulator.sv -----
// top level: sequential float sum of squares with optional square root
`default_nettype none
// Items are taken in the steps accept, square, round, accumulate, a new one
// only after accumulate; the running sum is a loop through the one multiplier
// and the one adder. A last item then loads the output register, waiting while
// an unread result is held. With take_root set, the bit-serial square root
// normalizes, takes 26 digit steps and rounds; zero, infinity or NaN skip them.
// The next item is accepted while a result waits on the output register.
module float_l2_norm_accumulator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata, // element_bits
	input  wire logic        s_tlast, // last_element
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata, // result_bits
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata
);
	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_RND, ST_ADD, ST_SQRT, ST_FIN} state_t;
	typedef enum logic [1:0] {SP_NORM, SP_ZERO, SP_INF, SP_NAN} spec_t;

	state_t              state_q;
	logic                take_root_q;
	logic                last_q;
	logic [31:0]         x_q;
	logic [47:0]         prod_s1;
	logic signed [11:0]  pe_s1;
	spec_t               spec_s1;
	logic [31:0]         sq_s2;
	logic [31:0]         sum_q;
	logic [31:0]         res_q;
	logic                start_q;
	logic                m_tvalid_q;
	logic [31:0]         m_tdata_q;
	fl2n_pkg::sqrt_stat_t sqrt_stat;

	logic [31:0]         sum_next;
	logic [31:0]         sq_next;

	function automatic logic [31:0] round_pack(input logic signed [11:0] e,
		input logic [25:0] w);
		logic [11:0] sh;
		logic [25:0] ws;
		logic [25:0] shifted;
		logic        st;
		logic [10:0] eb;
		logic [23:0] keep;
		logic        inc;
		logic [34:0] val;
		ws = w;
		eb = '0;
		if (e < 12'sd1) begin
			sh = 12'(12'sd1 - e);
			if (sh > 12'd26) begin
				shifted = '0;
				st = |w;
			end else begin
				shifted = w >> sh;
				st = (w & ~(26'h3FF_FFFF << sh)) != 26'd0;
			end
			ws = {shifted[25:1], shifted[0] | st};
		end else begin
			eb = 11'(e - 12'sd1);
		end
		keep = ws[25:2];
		inc = ws[1] & (ws[0] | keep[0]);
		val = 35'({eb, 23'd0}) + 35'(keep) + 35'(inc);
		if (val >= 35'(fl2n_pkg::POS_INF)) begin
			return fl2n_pkg::POS_INF;
		end
		return val[31:0];
	endfunction

	// square rounding
	always_comb begin
		unique case (spec_s1)
			SP_ZERO: sq_next = fl2n_pkg::POS_ZERO;
			SP_INF:  sq_next = fl2n_pkg::POS_INF;
			SP_NAN:  sq_next = fl2n_pkg::CANON_NAN;
			default: begin
				if (prod_s1[47]) begin
					sq_next = round_pack(pe_s1 + 12'sd1,
						{prod_s1[47:24], prod_s1[23], |prod_s1[22:0]});
				end else begin
					sq_next = round_pack(pe_s1,
						{prod_s1[46:23], prod_s1[22], |prod_s1[21:0]});
				end
			end
		endcase
	end

	// addition of two non-negative floats
	logic [7:0]  ea, eb2, ebig, d;
	logic [23:0] ma, mb, mbig, msml;
	logic [26:0] mbx, al;
	logic        ast;
	logic [27:0] s28;
	logic [26:0] s27;
	logic signed [11:0] esum;

	always_comb begin
		ast = 1'b0;
		ea = (sum_q[30:23] == 8'd0) ? 8'd1 : sum_q[30:23];
		eb2 = (sq_s2[30:23] == 8'd0) ? 8'd1 : sq_s2[30:23];
		ma = {sum_q[30:23] != 8'd0, sum_q[22:0]};
		mb = {sq_s2[30:23] != 8'd0, sq_s2[22:0]};
		if (ea >= eb2) begin
			ebig = ea; mbig = ma; msml = mb; d = ea - eb2;
		end else begin
			ebig = eb2; mbig = mb; msml = ma; d = eb2 - ea;
		end
		mbx = {msml, 3'b000};
		if (d >= 8'd27) begin
			al = {26'd0, |mbx};
		end else begin
			ast = (mbx & ~(27'h7FF_FFFF << d)) != 27'd0;
			al = (mbx >> d) | 27'(ast);
		end
		s28 = {1'b0, mbig, 3'b000} + {1'b0, al};
		if (s28[27]) begin
			s27 = {s28[27:2], s28[1] | s28[0]};
			esum = $signed({4'd0, ebig}) + 12'sd1;
		end else begin
			s27 = s28[26:0];
			esum = $signed({4'd0, ebig});
		end
		if (fl2n_pkg::is_nan(sum_q) || fl2n_pkg::is_nan(sq_s2)) begin
			sum_next = fl2n_pkg::CANON_NAN;
		end else if (sum_q[30:23] == 8'hFF || sq_s2[30:23] == 8'hFF) begin
			sum_next = fl2n_pkg::POS_INF;
		end else begin
			sum_next = round_pack(esum, {s27[26:2], |s27[1:0]});
		end
	end

	fl2n_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.in_bits (sum_q),
		.stat    (sqrt_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			take_root_q <= 1'b1;
			sum_q <= fl2n_pkg::POS_ZERO;
			start_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			start_q <= (state_q == ST_ADD) && last_q && take_root_q;
			if (cfg_we) begin
				take_root_q <= cfg_wdata;
			end
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						x_q <= s_tdata;
						last_q <= s_tlast;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_s1 <= {1'b1, x_q[22:0]} * {1'b1, x_q[22:0]};
					pe_s1 <= $signed({3'd0, x_q[30:23], 1'b0}) - 12'sd127;
					if (x_q[30:23] == 8'hFF) begin
						spec_s1 <= (x_q[22:0] != 23'd0) ? SP_NAN : SP_INF;
					end else if (x_q[30:23] == 8'd0) begin
						spec_s1 <= SP_ZERO;
					end else begin
						spec_s1 <= SP_NORM;
					end
					state_q <= ST_RND;
				end
				ST_RND: begin
					sq_s2 <= sq_next;
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					sum_q <= sum_next;
					res_q <= sum_next;
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (take_root_q) begin
						state_q <= ST_SQRT;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_SQRT: begin
					if (sqrt_stat.done) begin
						res_q <= sqrt_stat.bits;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= fl2n_pkg::is_nan(res_q) ? fl2n_pkg::CANON_NAN : res_q;
						sum_q <= fl2n_pkg::POS_ZERO;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
endmodule
`default_nettype wire

// ----- tb/sv/float_l2_norm_accumulator_tb.sv -----
// testbench for the float l2 norm accumulator: directed table, random vectors, bit-exact predictor
`default_nettype none
module float_l2_norm_accumulator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] bits;
		logic        last;
		logic        pinned;
		logic [31:0] want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        cfg_we;
	logic        cfg_wdata;

	logic [31:0] norm_q[$];
	logic [31:0] sum_acc;
	logic        root_mode;
	logic        pinned;
	logic [31:0] pinned_val;
	logic        calm;
	logic        squeeze;
	int          errors;
	int          items_in;
	int          norms_out;
	int          sqrt_norms;

	float_l2_norm_accumulator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic nan_bits(input logic [31:0] u);
		return (u[30:23] == 8'hFF) && (u[22:0] != 23'd0);
	endfunction

	// round mag * 2^e2 to single precision, nearest even
	function automatic logic [31:0] fp_round(input logic sgn, input logic [319:0] mag,
			input int e2);
		int p;
		int sh;
		int k;
		int ex;
		logic [319:0] q;
		logic rb;
		logic st;
		if (mag == '0) begin
			return {sgn, 31'd0};
		end
		p = 319;
		while (!mag[p]) p--;
		sh = p - 23;
		if (sh < -149 - e2) sh = -149 - e2;
		if (sh > 0) begin
			q = mag >> sh;
			rb = mag[sh-1];
			st = |(mag & ((320'd1 << (sh - 1)) - 320'd1));
			if (rb && (st || q[0])) q = q + 320'd1;
		end else begin
			q = mag << (-sh);
		end
		k = sh + e2;
		if (q[24]) begin
			q = q >> 1;
			k++;
		end
		if (q[23]) begin
			ex = k + 150;
			if (ex >= 255) return {sgn, 8'hFF, 23'd0};
			return {sgn, ex[7:0], q[22:0]};
		end
		return {sgn, 8'd0, q[22:0]};
	endfunction

	function automatic logic [319:0] fp_mant(input logic [31:0] u, output int k);
		if (u[30:23] == 8'd0) begin
			k = -149;
			return {297'd0, u[22:0]};
		end
		k = int'(u[30:23]) - 150;
		return {296'd0, 1'b1, u[22:0]};
	endfunction

	function automatic logic [31:0] fp_square(input logic [31:0] x);
		int k;
		logic [319:0] m;
		if (nan_bits(x)) return fl2n_pkg::CANON_NAN;
		if (x[30:0] == fl2n_pkg::POS_INF[30:0]) return fl2n_pkg::POS_INF;
		m = fp_mant(x, k);
		return fp_round(1'b0, m * m, 2 * k);
	endfunction

	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		int ka;
		int kb;
		logic [319:0] ma;
		logic [319:0] mb;
		logic [319:0] mag;
		logic sgn;
		if (nan_bits(a) || nan_bits(b)) return fl2n_pkg::CANON_NAN;
		if (a[30:0] == fl2n_pkg::POS_INF[30:0] && b[30:0] == fl2n_pkg::POS_INF[30:0])
			return (a[31] == b[31]) ? a : fl2n_pkg::CANON_NAN;
		if (a[30:0] == fl2n_pkg::POS_INF[30:0]) return a;
		if (b[30:0] == fl2n_pkg::POS_INF[30:0]) return b;
		ma = fp_mant(a, ka) << (ka + 149);
		mb = fp_mant(b, kb) << (kb + 149);
		if (a[31] == b[31]) begin
			mag = ma + mb;
			sgn = a[31];
		end else if (ma >= mb) begin
			mag = ma - mb;
			sgn = a[31];
		end else begin
			mag = mb - ma;
			sgn = b[31];
		end
		if (mag == '0) sgn = a[31] & b[31];
		return fp_round(sgn, mag, -149);
	endfunction

	function automatic logic [31:0] fp_sqrt(input logic [31:0] u);
		logic [63:0] m;
		logic [63:0] num;
		logic [63:0] r;
		logic [63:0] t;
		logic [31:0] q;
		int p;
		int bexp;
		if (nan_bits(u)) return fl2n_pkg::CANON_NAN;
		if (u[30:0] == 31'd0) return u;
		if (u[31]) return fl2n_pkg::CANON_NAN;
		if (u[30:23] == 8'hFF) return u;
		if (u[30:23] == 8'd0) begin
			m = {41'd0, u[22:0]};
			p = -149;
			while (!m[23]) begin
				m = m << 1;
				p--;
			end
		end else begin
			m = {40'd0, 1'b1, u[22:0]};
			p = int'(u[30:23]) - 150;
		end
		if (p % 2 != 0) begin
			m = m << 1;
			p -= 1;
		end else begin
			m = m << 2;
			p -= 2;
		end
		num = m << 24;
		r = 64'd0;
		for (int b = 25; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= num) r = t;
		end
		q = r[32:1];
		if (r[0] && ((num != r * r) || q[0])) q = q + 32'd1;
		bexp = p / 2 - 11 + 23 + 127;
		if (q[24]) begin
			q = q >> 1;
			bexp++;
		end
		return {1'b0, bexp[7:0], q[22:0]};
	endfunction

	// predictor and result checker
	always @(posedge clk or negedge arst_n) begin
		logic [31:0] r;
		logic [31:0] w;
		if (!arst_n) begin
			sum_acc = fl2n_pkg::POS_ZERO;
			root_mode = 1'b1;
		end else begin
			if (cfg_we) root_mode = cfg_wdata;
			if (s_tvalid && s_tready) begin
				items_in++;
				sum_acc = fp_add(sum_acc, fp_square(s_tdata));
				if (s_tlast) begin
					r = root_mode ? fp_sqrt(sum_acc) : sum_acc;
					if (nan_bits(r)) r = fl2n_pkg::CANON_NAN;
					norm_q.push_back(pinned ? pinned_val : r);
					if (root_mode) sqrt_norms++;
					sum_acc = fl2n_pkg::POS_ZERO;
				end
			end
			if (m_tvalid && m_tready) begin
				norms_out++;
				if (norm_q.size() == 0) begin
					errors++;
					$display("%t: unexpected result %h", $time, m_tdata);
				end else begin
					w = norm_q.pop_front();
					if (m_tdata !== w) begin
						errors++;
						$display("%t: result expected %h actual %h", $time, w, m_tdata);
					end
				end
			end
		end
	end

	// receiver
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze) begin
				squeeze = 1'b0;
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic [31:0] bits, input logic last, input logic pin,
			input logic [31:0] want);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= bits;
		s_tlast <= last;
		pinned = pin;
		pinned_val = want;
		do @(posedge clk); while (!s_tready);
		if (!calm && $urandom_range(0, 7) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19) - 1) @(negedge clk);
		end
	endtask

	task automatic set_root(input logic v);
		@(negedge clk);
		s_tvalid <= 1'b0;
		pinned = 1'b0;
		while (norm_q.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_elem();
		logic [31:0] v;
		v = $urandom();
		case ($urandom_range(0, 9))
			0: v[30:0] = 31'd0;
			1: v[30:23] = 8'hFF;
			2: v[30:23] = 8'd0;
			3: v[30:23] = 8'hFE;
			4, 5: ;
			default: v[30:23] = 8'($urandom_range(100, 150));
		endcase
		return v;
	endfunction

	row_t rows[$];

	initial begin
		int len;
		logic noise;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		pinned = 1'b0;
		pinned_val = '0;
		calm = 1'b0;
		squeeze = 1'b0;
		errors = 0;
		items_in = 0;
		norms_out = 0;
		sqrt_norms = 0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		rows = '{
			'{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
			'{32'h8000_0000, 1'b1, 1'b1, 32'h0000_0000},
			'{32'h4040_0000, 1'b1, 1'b1, 32'h4040_0000},
			'{32'h4040_0000, 1'b0, 1'b0, 32'h0},
			'{32'h4080_0000, 1'b1, 1'b1, 32'h40A0_0000},
			'{32'hC000_0000, 1'b1, 1'b1, 32'h4000_0000},
			'{32'h7F80_0000, 1'b1, 1'b1, 32'h7F80_0000},
			'{32'hFF80_0000, 1'b1, 1'b1, 32'h7F80_0000},
			'{32'h7FC0_0001, 1'b1, 1'b1, 32'h7FC0_0000},
			'{32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7FC0_0000},
			'{32'h7F7F_FFFF, 1'b1, 1'b1, 32'h7F80_0000},
			'{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0000},
			'{32'h8000_0001, 1'b0, 1'b0, 32'h0},
			'{32'h007F_FFFF, 1'b1, 1'b0, 32'h0},
			'{32'h1F80_0000, 1'b1, 1'b0, 32'h0},
			'{32'h3F80_0001, 1'b0, 1'b0, 32'h0},
			'{32'h7F80_0000, 1'b0, 1'b0, 32'h0},
			'{32'h4000_0000, 1'b1, 1'b1, 32'h7F80_0000},
			'{32'h5F80_0000, 1'b0, 1'b0, 32'h0},
			'{32'h5F80_0000, 1'b1, 1'b0, 32'h0}
		};
		foreach (rows[i]) send_item(rows[i].bits, rows[i].last, rows[i].pinned, rows[i].want);

		for (int ph = 0; ph < 5; ph++) begin
			set_root(ph[0] ? 1'b1 : (ph == 4));
			if (ph == 1) squeeze = 1'b1;
			if (ph == 4) calm = 1'b1;
			for (int n = 0; n < 116; ) begin
				len = (ph == 1) ? 1 : $urandom_range(1, 8);
				noise = ($urandom_range(0, 9) == 0);
				for (int j = 0; j < len; j++)
					send_item(noise ? $urandom() : rand_elem(), j == len - 1, 1'b0, 32'h0);
				n += len;
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (norm_q.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("covered %0d items and %0d results, %0d of them square roots",
			items_in, norms_out, sqrt_norms);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
`default_nettype wire
